@@ hw/rtl/line_camera_pd_steering_macros.svh @@
// Assertion macros used by the steering block's checker.
`ifndef LINE_CAMERA_PD_STEERING_MACROS_SVH
`define LINE_CAMERA_PD_STEERING_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define LCPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define LCPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// What must hold in the cycle after a reset cycle.
`define LCPD_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lcpd_pkg.sv @@
// Types and constants of the line-camera PD steering block.
package lcpd_pkg;

    localparam int NUM_ZONES = 6;
    localparam int COUNT_W   = 6;
    localparam int ERR_W     = 9;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int GAIN_W    = 8;
    localparam int PW_W      = 12;
    localparam int THR_W     = 7;
    localparam int DUTY_W    = 15;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;

    // Scan window and zone bounds, left-3 first.
    localparam int SCAN_FIRST = 10;
    localparam int SCAN_LAST  = 109;
    localparam int ZONE_LO [NUM_ZONES] = '{8, 14, 26, 65, 91, 117};
    localparam int ZONE_HI [NUM_ZONES] = '{13, 25, 64, 90, 116, 122};
    localparam int ZONE_WEIGHT [NUM_ZONES] = '{15, 5, 2, -2, -5, -15};

    localparam logic [DUTY_W-1:0] PWM_PERIOD = 15'd20000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KD         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_DUTY  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DUTY = 3'd7;

    typedef enum logic [1:0] {
        SIDE_CENTRE = 2'd0,
        SIDE_LEFT   = 2'd1,
        SIDE_RIGHT  = 2'd2
    } t_side;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] kd;
        logic [PW_W-1:0]   setpoint;
        logic [THR_W-1:0]  lost_threshold;
        logic [PW_W-1:0]   clamp_low;
        logic [PW_W-1:0]   clamp_high;
        logic [PW_W-1:0]   left_limit_duty;
        logic [PW_W-1:0]   right_limit_duty;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        kp:               8'd24,
        kd:               8'd8,
        setpoint:         12'd1300,
        lost_threshold:   7'd5,
        clamp_low:        12'd1124,
        clamp_high:       12'd1790,
        left_limit_duty:  12'd1100,
        right_limit_duty: 12'd1500
    };

    // Zone counts of one finished line.
    typedef struct packed {
        logic [NUM_ZONES-1:0][COUNT_W-1:0] counts;
    } t_line;

    typedef struct packed {
        logic [DUTY_W-1:0]       duty_us;
        logic signed [ERR_W-1:0] line_error;
        logic                    line_lost;
    } t_result;

endpackage

@@ hw/rtl/lcpd_fifo.sv @@
// Small register queue with a first-word-fall-through read side.
module lcpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    // DEPTH must be a power of two so that the pointers wrap on their own.
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

@@ hw/rtl/lcpd_front.sv @@
// Pixel front end: scan position, zone counting and line hand-off.
module lcpd_front #(
    parameter int LINE_PIXELS = 127
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_pixel_dark,
    input  logic          i_last_pixel,
    output logic          o_line_push,
    output lcpd_pkg::t_line o_line
);
    import lcpd_pkg::*;

    localparam int PIX_W = $clog2(LINE_PIXELS + 1);

    logic [PIX_W-1:0]   r_pos;
    logic [COUNT_W-1:0] r_counts [NUM_ZONES];
    logic [PIX_W-1:0]   n_pos;
    logic [COUNT_W-1:0] n_counts [NUM_ZONES];
    logic [COUNT_W-1:0] cnt_inc  [NUM_ZONES];
    logic               in_scan;
    logic [NUM_ZONES-1:0] hit;

    always_comb begin
        in_scan = (int'(r_pos) >= SCAN_FIRST) && (int'(r_pos) <= SCAN_LAST);
        for (int z = 0; z < NUM_ZONES; z++) begin
            hit[z] = i_pixel_dark && in_scan &&
                     (int'(r_pos) >= ZONE_LO[z]) && (int'(r_pos) <= ZONE_HI[z]);
            cnt_inc[z] = r_counts[z] + COUNT_W'(hit[z]);
            o_line.counts[z] = cnt_inc[z];
        end

        n_pos       = r_pos;
        o_line_push = 1'b0;
        for (int z = 0; z < NUM_ZONES; z++) begin
            n_counts[z] = r_counts[z];
        end

        if (i_accept) begin
            if (i_last_pixel) begin
                o_line_push = 1'b1;
                n_pos       = '0;
                for (int z = 0; z < NUM_ZONES; z++) begin
                    n_counts[z] = '0;
                end
            end else begin
                for (int z = 0; z < NUM_ZONES; z++) begin
                    n_counts[z] = cnt_inc[z];
                end
                if (r_pos < PIX_W'(LINE_PIXELS)) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int z = 0; z < NUM_ZONES; z++) begin
                r_counts[z] <= '0;
            end
        end else begin
            r_pos <= n_pos;
            for (int z = 0; z < NUM_ZONES; z++) begin
                r_counts[z] <= n_counts[z];
            end
        end
    end

endmodule

@@ hw/rtl/lcpd_back.sv @@
// Steering back end: error, PD products and duty selection in three stages.
module lcpd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcpd_pkg::t_cfg    i_cfg,
    input  lcpd_pkg::t_line   i_line,
    input  logic              i_line_empty,
    output logic              o_line_pop,
    output logic              o_res_push,
    output lcpd_pkg::t_result o_res,
    input  logic              i_res_full
);
    import lcpd_pkg::*;

    localparam int ACC_W = ERR_W + 2;
    localparam int TOT_W = COUNT_W + 3;
    localparam int PK_W  = GAIN_W + ERR_W;
    localparam int PDK_W = GAIN_W + DIFF_W;
    localparam int PD_W  = PDK_W + 1;
    localparam int V_W   = PD_W + 2;

    logic adv;

    // Stage one: weighted error and lost decision.
    logic signed [ACC_W-1:0]  acc;
    logic [TOT_W-1:0]         tot;
    logic signed [ERR_W-1:0]  s1_e;
    logic signed [DIFF_W-1:0] s1_diff;
    logic                     s1_lost;

    logic                     r_v1;
    logic signed [ERR_W-1:0]  r_s1_e;
    logic signed [DIFF_W-1:0] r_s1_diff;
    logic                     r_s1_lost;
    t_side                    r_s1_side;
    logic signed [ERR_W-1:0]  r_prev;
    t_side                    r_side;
    t_side                    n_side;

    // Stage two: products.
    logic                     r_v2;
    logic signed [PK_W-1:0]   r_s2_pk;
    logic signed [PDK_W-1:0]  r_s2_pdk;
    logic signed [ERR_W-1:0]  r_s2_e;
    logic                     r_s2_lost;
    t_side                    r_s2_side;

    // Stage three: duty.
    logic signed [PD_W-1:0]   pd;
    logic signed [V_W-1:0]    v;
    logic [V_W-5:0]           duty_pos;
    logic [V_W-5:0]           duty_lo;
    logic [PW_W-1:0]          duty_seen;
    logic [PW_W-1:0]          n_last_duty;
    logic [PW_W-1:0]          r_last_duty;

    assign adv        = !(r_v2 && i_res_full);
    assign o_line_pop = adv && !i_line_empty;
    assign o_res_push = adv && r_v2;

    always_comb begin
        acc = '0;
        tot = '0;
        for (int z = 0; z < NUM_ZONES; z++) begin
            acc = acc + ACC_W'(ZONE_WEIGHT[z]) *
                        $signed({{(ACC_W-COUNT_W){1'b0}}, i_line.counts[z]});
            tot = tot + TOT_W'(i_line.counts[z]);
        end
        s1_e    = acc[ERR_W-1:0];
        s1_diff = DIFF_W'(s1_e) - DIFF_W'(r_prev);
        s1_lost = (tot < TOT_W'(i_cfg.lost_threshold));

        if (s1_e == '0) begin
            n_side = SIDE_CENTRE;
        end else if (s1_e[ERR_W-1]) begin
            n_side = SIDE_RIGHT;
        end else begin
            n_side = SIDE_LEFT;
        end
    end

    always_comb begin
        pd = PD_W'(r_s2_pk) + PD_W'(r_s2_pdk);
        v  = $signed({{(V_W-PW_W-4){1'b0}}, i_cfg.setpoint, 4'b0000}) - V_W'(pd);
        // Arithmetic shift by four floors; a negative value saturates to zero.
        duty_pos = v[V_W-1] ? '0 : v[V_W-1:4];
        if (duty_pos < (V_W-4)'(i_cfg.clamp_low)) begin
            duty_lo = (V_W-4)'(i_cfg.left_limit_duty);
        end else begin
            duty_lo = duty_pos;
        end
        if (duty_lo > (V_W-4)'(i_cfg.clamp_high)) begin
            duty_seen = i_cfg.right_limit_duty;
        end else begin
            duty_seen = duty_lo[PW_W-1:0];
        end

        if (r_s2_lost) begin
            case (r_s2_side)
                SIDE_LEFT:  n_last_duty = i_cfg.left_limit_duty;
                SIDE_RIGHT: n_last_duty = i_cfg.right_limit_duty;
                default:    n_last_duty = r_last_duty;
            endcase
        end else begin
            n_last_duty = duty_seen;
        end

        o_res.duty_us    = PWM_PERIOD - DUTY_W'(n_last_duty);
        o_res.line_error = r_s2_e;
        o_res.line_lost  = r_s2_lost;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_prev      <= '0;
            r_side      <= SIDE_CENTRE;
            r_last_duty <= '0;
        end else begin
            if (adv) begin
                r_v1 <= !i_line_empty;
                r_v2 <= r_v1;
            end
            if (o_line_pop && !s1_lost) begin
                r_prev <= s1_e;
                r_side <= n_side;
            end
            if (o_res_push) begin
                r_last_duty <= n_last_duty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_e    <= s1_e;
            r_s1_diff <= s1_diff;
            r_s1_lost <= s1_lost;
            r_s1_side <= r_side;
            r_s2_pk   <= $signed({1'b0, i_cfg.kp}) * r_s1_e;
            r_s2_pdk  <= $signed({1'b0, i_cfg.kd}) * r_s1_diff;
            r_s2_e    <= r_s1_e;
            r_s2_lost <= r_s1_lost;
            r_s2_side <= r_s1_side;
        end
    end

endmodule

@@ hw/rtl/line_camera_pd_steering.sv @@
// Line-camera PD steering: one pixel per item in, one servo result per line out.
// Throughput: one pixel item per clock; a line-end item may follow another every clock;
// both hold only while the line queue is not full. A line's result reaches the head of
// the result queue after the line queue and the three back-end stages (error, multiply, duty).
// Reset (synchronous, active low) loads the register defaults, clears the scan
// position, zone counts, previous error, remembered side and duty, and empties both queues.
module line_camera_pd_steering #(
    parameter int LINE_PIXELS = 127,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // Pixel items.
    input  logic                           push,
    output logic                           full,
    input  logic                           i_pixel_dark,
    input  logic                           i_last_pixel,

    // Result items.
    output logic                           empty,
    input  logic                           pop,
    output logic [lcpd_pkg::DUTY_W-1:0]    o_duty_us,
    output logic signed [lcpd_pkg::ERR_W-1:0] o_line_error,
    output logic                           o_line_lost,

    // Register writes.
    input  logic                           i_cfg_we,
    input  logic [lcpd_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [lcpd_pkg::CFG_W-1:0]     i_cfg_data
);
    import lcpd_pkg::*;

    t_cfg    r_cfg;
    logic    in_accept;
    logic    line_push;
    t_line   line_in;
    t_line   line_head;
    logic    line_empty;
    logic    line_pop;
    logic    res_push;
    logic    res_full;
    t_result res_in;
    t_result res_head;

    // Register file. The user must write it only while the block is idle; the block does
    // not enforce this, and the back end reads these values directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_KP:         r_cfg.kp               <= i_cfg_data[GAIN_W-1:0];
                REG_KD:         r_cfg.kd               <= i_cfg_data[GAIN_W-1:0];
                REG_SETPOINT:   r_cfg.setpoint         <= i_cfg_data[PW_W-1:0];
                REG_LOST_THR:   r_cfg.lost_threshold   <= i_cfg_data[THR_W-1:0];
                REG_CLAMP_LOW:  r_cfg.clamp_low        <= i_cfg_data[PW_W-1:0];
                REG_CLAMP_HIGH: r_cfg.clamp_high       <= i_cfg_data[PW_W-1:0];
                REG_LEFT_DUTY:  r_cfg.left_limit_duty  <= i_cfg_data[PW_W-1:0];
                REG_RIGHT_DUTY: r_cfg.right_limit_duty <= i_cfg_data[PW_W-1:0];
                default:        r_cfg                  <= r_cfg;
            endcase
        end
    end

    // The front end stalls only when the line queue is full. Ordinary pixels
    // never touch the queue, but holding them too keeps the rule simple.
    assign in_accept = push && !full;

    lcpd_front #(
        .LINE_PIXELS (LINE_PIXELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_pixel_dark (i_pixel_dark),
        .i_last_pixel (i_last_pixel),
        .o_line_push  (line_push),
        .o_line       (line_in)
    );

    // Finished lines wait here for the back end.
    lcpd_fifo #(
        .WIDTH ($bits(t_line)),
        .DEPTH (QUEUE_DEPTH)
    ) u_line_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (line_push),
        .i_wdata (line_in),
        .i_rd    (line_pop),
        .o_rdata (line_head),
        .o_full  (full),
        .o_empty (line_empty)
    );

    // The back end advances as one pipe and holds while its last stage has a
    // result and the result queue is full.
    lcpd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_line       (line_head),
        .i_line_empty (line_empty),
        .o_line_pop   (line_pop),
        .o_res_push   (res_push),
        .o_res        (res_in),
        .i_res_full   (res_full)
    );

    // Results wait here until the consumer pops them.
    lcpd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res_in),
        .i_rd    (pop),
        .o_rdata (res_head),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_duty_us    = res_head.duty_us;
    assign o_line_error = res_head.line_error;
    assign o_line_lost  = res_head.line_lost;

endmodule

@@ hw/rtl/lcpd_checker.sv @@
// Port-level checks of the steering block and their binding to the top level.
`include "line_camera_pd_steering_macros.svh"

module lcpd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic [14:0]       o_duty_us,
    input logic signed [8:0] o_line_error,
    input logic              o_line_lost
);
    // The result queue comes out of reset empty.
    `LCPD_ASSERT_RST(a_empty_after_reset, empty, "result queue not empty after reset")

    // A waiting result that is not popped stays as it is.
    `LCPD_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(o_duty_us) && $stable(o_line_error) && $stable(o_line_lost), "waiting result changed")

    // The scan window bounds the weighted error to -147..198.
    `LCPD_ASSERT_IMP(a_error_range, !empty, (o_line_error >= -9'sd147) && (o_line_error <= 9'sd198), "line error out of range")

    // The steering duty never exceeds twelve bits, so the output stays near the period.
    `LCPD_ASSERT_IMP(a_duty_range, !empty, (o_duty_us >= 15'd15905) && (o_duty_us <= 15'd20000), "duty output out of range")

endmodule

bind line_camera_pd_steering lcpd_checker u_lcpd_checker (.*);
